@@ hw/rtl/sfl_pkg.sv @@
// Shared types and constants for the slot free-list allocator.
// Holds the operation codes, the controller states and the result record.
// No dependencies.
package sfl_pkg;

  // Fixed field widths of the stream payload
  localparam int FUNC_W      = 2;
  localparam int SLOT_W      = 9;
  localparam int PAYLOAD_W   = 32;
  localparam int INDEX_W     = 8;
  localparam int CURSOR_W    = 9;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // Operation selector; the fourth code is unknown and fails with no change
  typedef enum logic [FUNC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_FREE   = 2'd1,
    OP_SCAN   = 2'd2
  } func_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LOOK = 1'b1
  } state_t;

  typedef struct packed {
    logic                 ok;
    logic [INDEX_W-1:0]   slot_index;
    logic [PAYLOAD_W-1:0] found_payload;
    logic [CURSOR_W-1:0]  next_cursor;
  } result_t;

endpackage

@@ hw/rtl/sfl_ram.sv @@
// Simple dual-port synchronous RAM: one write port, one read port.
// Read data is registered and holds while no read is enabled.
// Depends on nothing.
module sfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/sfl_ctrl.sv @@
// Allocator controller: free-list head, high-water mark and the operation sequencer.
// Drives the link/used memory and the payload memory with read-modify-write steps.
// Depends on sfl_pkg.
module sfl_ctrl
  import sfl_pkg::*;
#(
  parameter int SLOTS      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  func_t                       in_func,
  input  logic [SLOT_W-1:0]           in_slot,
  input  logic [PAYLOAD_W-1:0]        in_payload,
  output logic                        res_valid,
  input  logic                        res_ready,
  output result_t                     res,
  output logic                        mem_re,
  output logic [$clog2(SLOTS)-1:0]    mem_raddr,
  output logic [$clog2(SLOTS)-1:0]    mem_waddr,
  output logic                        meta_we,
  output logic [$clog2(SLOTS+1):0]    meta_wdata,
  input  logic [$clog2(SLOTS+1):0]    meta_rdata,
  output logic                        pay_we,
  output logic [DATA_WIDTH-1:0]       pay_wdata,
  input  logic [DATA_WIDTH-1:0]       pay_rdata
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int MW    = CNT_W + 1;
  localparam int CW    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  state_t                state, state_next;
  func_t                 op;
  logic [CW-1:0]         cur, cur_next;
  logic [DATA_WIDTH-1:0] pay_hold;
  logic [CNT_W-1:0]      free_head, free_head_next;
  logic [CNT_W-1:0]      hw, hw_next;

  logic [CW-1:0]         in_cur;
  logic [CW-1:0]         cur_inc;
  logic                  cur_in_range;
  logic                  cur_used;
  logic                  cur_last;
  logic                  head_ok;
  logic                  head_fresh;
  logic [CNT_W-1:0]      link_pop;
  logic                  free_ok;

  // Slots at or above the high-water mark were never allocated: free, linked to i+1
  assign in_cur       = CW'(in_slot);
  assign cur_inc      = cur + CW'(1);
  assign cur_in_range = cur < CW'(SLOTS);
  assign cur_used     = cur_in_range && (cur < CW'(hw)) && meta_rdata[MW-1];
  assign cur_last     = !cur_in_range || (cur == CW'(SLOTS - 1));
  assign head_ok      = free_head != CNT_W'(SLOTS);
  assign head_fresh   = free_head >= hw;
  assign link_pop     = head_fresh ? free_head + CNT_W'(1) : meta_rdata[CNT_W-1:0];
  assign free_ok      = cur_used;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (res_valid && res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory access, bookkeeping updates and result
  always_comb begin
    in_ready       = (state == ST_IDLE);
    mem_re         = 1'b0;
    mem_raddr      = '0;
    mem_waddr      = '0;
    meta_we        = 1'b0;
    meta_wdata     = '0;
    pay_we         = 1'b0;
    pay_wdata      = pay_hold;
    res_valid      = 1'b0;
    res            = '0;
    free_head_next = free_head;
    hw_next        = hw;
    cur_next       = cur;
    case (state)
      ST_IDLE: begin
        // Issue the first read at the accepted transaction
        if (in_valid) begin
          mem_re    = 1'b1;
          mem_raddr = (in_func == OP_INSERT) ? free_head[IDX_W-1:0] : in_cur[IDX_W-1:0];
          cur_next  = in_cur;
        end
      end
      ST_LOOK: begin
        case (op)
          OP_INSERT: begin
            // Pop the head, store the payload, mark the slot used
            res_valid = 1'b1;
            if (head_ok) begin
              res.ok         = 1'b1;
              res.slot_index = INDEX_W'(free_head);
              mem_waddr      = free_head[IDX_W-1:0];
              meta_wdata     = {1'b1, link_pop};
              meta_we        = res_ready;
              pay_we         = res_ready;
              if (res_ready) begin
                free_head_next = link_pop;
                if (head_fresh) begin
                  hw_next = free_head + CNT_W'(1);
                end
              end
            end
          end
          OP_FREE: begin
            // Push a used slot back on the list
            res_valid = 1'b1;
            if (free_ok) begin
              res.ok     = 1'b1;
              mem_waddr  = cur[IDX_W-1:0];
              meta_wdata = {1'b0, free_head};
              meta_we    = res_ready;
              if (res_ready) begin
                free_head_next = CNT_W'(cur);
              end
            end
          end
          OP_SCAN: begin
            // Test one slot a cycle; advance the cursor until a hit or the end
            if (cur_used) begin
              res_valid         = 1'b1;
              res.ok            = 1'b1;
              res.slot_index    = cur[INDEX_W-1:0];
              res.found_payload = PAYLOAD_W'(pay_rdata);
              res.next_cursor   = cur_inc[CURSOR_W-1:0];
            end else if (cur_last) begin
              res_valid       = 1'b1;
              res.next_cursor = CURSOR_W'(SLOTS);
            end else begin
              mem_re    = 1'b1;
              mem_raddr = cur_inc[IDX_W-1:0];
              cur_next  = cur_inc;
            end
          end
          default: begin
            res_valid = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      free_head <= '0;
      hw        <= '0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      hw        <= hw_next;
    end
  end

  // Hold the transaction fields
  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (in_valid && in_ready) begin
      op       <= in_func;
      pay_hold <= DATA_WIDTH'(in_payload);
    end
  end

`ifndef SYNTHESIS
  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    free_head <= CNT_W'(SLOTS))
    else $error("free list head beyond table");

  a_head_fresh: assert property (@(posedge clk) disable iff (rst)
    (free_head >= hw) |-> (free_head == hw))
    else $error("free list head skips untouched slots");

  a_pay_with_meta: assert property (@(posedge clk) disable iff (rst)
    pay_we |-> (meta_we && op == OP_INSERT && state == ST_LOOK))
    else $error("payload written outside an allocation");

  a_pop_free_slot: assert property (@(posedge clk) disable iff (rst)
    pay_we |-> (head_fresh || !meta_rdata[MW-1]))
    else $error("allocated a slot already in use");
`endif

endmodule

@@ hw/rtl/slot_free_list_allocator.sv @@
// Slot free-list allocator: insert, free and scan over a table of SLOTS slots.
// Insert and free read the link/used memory at accept and, if they succeed, write it back;
// an unknown operation only reads it. A new transaction is accepted once the result is taken.
// A scan from cursor c to the next used slot makes one memory read per slot.
// Reset: synchronous; the table is usable the cycle after reset, no clearing pass.
module slot_free_list_allocator
  import sfl_pkg::*;
#(
  parameter int SLOTS      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // slot[8:0], payload[40:9], zero fill
  input  logic [FUNC_W-1:0]      s_tuser,   // func[1:0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // slot_index[7:0], found_payload[39:8],
                                            // next_cursor[48:40], zero fill
  output logic [0:0]             m_tuser    // ok[0]
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int MW    = $clog2(SLOTS + 1) + 1;

  logic                  res_valid;
  logic                  res_ready;
  result_t               res;
  result_t               out_res;
  logic                  mem_re;
  logic [IDX_W-1:0]      mem_raddr;
  logic [IDX_W-1:0]      mem_waddr;
  logic                  meta_we;
  logic [MW-1:0]         meta_wdata;
  logic [MW-1:0]         meta_rdata;
  logic                  pay_we;
  logic [DATA_WIDTH-1:0] pay_wdata;
  logic [DATA_WIDTH-1:0] pay_rdata;

  sfl_ctrl #(
    .SLOTS      (SLOTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_func    (func_t'(s_tuser)),
    .in_slot    (s_tdata[SLOT_W-1:0]),
    .in_payload (s_tdata[SLOT_W+PAYLOAD_W-1:SLOT_W]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_waddr  (mem_waddr),
    .meta_we    (meta_we),
    .meta_wdata (meta_wdata),
    .meta_rdata (meta_rdata),
    .pay_we     (pay_we),
    .pay_wdata  (pay_wdata),
    .pay_rdata  (pay_rdata)
  );

  // Link and used flag per slot
  sfl_ram #(
    .WIDTH (MW),
    .DEPTH (SLOTS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (mem_waddr),
    .wdata (meta_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (meta_rdata)
  );

  // Payload per slot
  sfl_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (SLOTS)
  ) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (mem_waddr),
    .wdata (pay_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (pay_rdata)
  );

  // Output register: load when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  // Pack the result transaction
  assign m_tdata = {{(OUT_TDATA_W - INDEX_W - PAYLOAD_W - CURSOR_W){1'b0}},
                    out_res.next_cursor, out_res.found_payload, out_res.slot_index};
  assign m_tuser = out_res.ok;

endmodule
